/* hdl/rplm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rplm_pkg
// Shared types and constants for the radio pipe lease manager.
// ----------------------------------------------------------------------------
package rplm_pkg;

  localparam int unsigned NUM_PIPES  = 6;
  localparam int unsigned PIPE_IDX_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  // result fields only report the first six pipes
  localparam int unsigned OUT_PIPES  = (NUM_PIPES < 6) ? NUM_PIPES : 6;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [1:0] OP_SWEEP  = 2'd0;
  localparam logic [1:0] OP_STATUS = 2'd1;
  localparam logic [1:0] OP_LEASE  = 2'd2;

  typedef enum logic [1:0] {
    MODE_FREE  = 2'd0,
    MODE_USED  = 2'd1,
    MODE_RESET = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] last_heard;
    logic        ack;
  } pipe_state_t;

  typedef struct packed {
    logic step;
    logic lease_hit;
    logic status_hit;
    logic err_hit;
  } pipe_ctrl_t;

endpackage : rplm_pkg
`default_nettype wire

/* hdl/rplm_pipe_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rplm_pipe_update
// Next-state logic of one pipe: lease or status refresh, then timeout sweep.
// ----------------------------------------------------------------------------
module rplm_pipe_update
  import rplm_pkg::*;
(
  input  wire pipe_ctrl_t  ctrl,
  input  wire pipe_state_t cur,
  input  wire logic [31:0] now_ms,
  input  wire logic [15:0] timeout_ms,
  output pipe_state_t      nxt
);

  mode_t       mode1;
  logic [31:0] heard1;
  logic [31:0] gap;
  logic        silent;

  always_comb begin
    mode1  = ctrl.lease_hit ? MODE_USED : cur.mode;
    heard1 = (ctrl.lease_hit || ctrl.status_hit) ? now_ms : cur.last_heard;
    // wraps modulo 2^32
    gap    = now_ms - heard1;
    silent = gap > {16'd0, timeout_ms};
  end

  always_comb begin
    nxt = cur;
    if (ctrl.step) begin
      nxt.mode       = mode1;
      nxt.last_heard = heard1;
      if (mode1 == MODE_RESET && silent) begin
        nxt.mode = MODE_FREE;
        nxt.ack  = 1'b1;
      end
      // the error pipe may be freed above and sent straight back to resetting
      if (ctrl.err_hit || (nxt.mode == MODE_USED && silent)) begin
        nxt.mode = MODE_RESET;
        nxt.ack  = 1'b0;
      end
    end
  end

endmodule : rplm_pipe_update
`default_nettype wire

/* hdl/radio_pipe_lease_manager_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// radio_pipe_lease_manager_core
// Lease table of radio receive pipes with status refresh and silence sweep.
// ----------------------------------------------------------------------------
// path: input register, then one pass of pipe logic into the result register;
//   the result strobe rises with the result register
// throughput: one item per cycle; busy stays low, the table updates in the
//   same edge that registers the result
// reset: all pipes free, acknowledge on, timestamps zero, timeout 1000 ms;
//   reply addresses hold nothing until a lease writes them
module radio_pipe_lease_manager_core
  import rplm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_now_ms,
  input  wire logic [2:0]  in_pipe_index,
  input  wire logic [39:0] in_requester_addr,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  output logic             out_valid,
  output logic [5:0]       out_ack_mask,
  output logic             out_lease_granted,
  output logic             out_lease_full,
  output logic [2:0]       out_lease_pipe,
  output logic             out_status_accepted,
  output logic             out_status_rejected,
  output logic [11:0]      out_state_bits,
  output logic [39:0]      out_granted_reply_addr
);

  logic        in_vld_r;
  logic [1:0]  op_r;
  logic [31:0] now_r;
  logic [2:0]  idx_r;
  logic [39:0] req_r;
  logic [15:0] timeout_r;

  pipe_state_t st_r    [NUM_PIPES];
  pipe_state_t st_nxt  [NUM_PIPES];
  pipe_ctrl_t  ctrl    [NUM_PIPES];
  logic [39:0] reply_addr_r [NUM_PIPES];

  logic                  free_found;
  logic [PIPE_IDX_W-1:0] free_idx;
  logic [PIPE_IDX_W-1:0] idx_sel;
  logic                  idx_ok;
  logic                  is_lease;
  logic                  is_status;
  logic                  status_used;
  logic                  grant;

  logic        out_valid_r;
  logic [5:0]  ack_nxt,   ack_r;
  logic [11:0] modes_nxt, modes_r;
  logic [39:0] addr_nxt,  addr_r;
  logic        granted_r, full_r, accepted_r, rejected_r;
  logic [2:0]  lease_pipe_nxt, lease_pipe_r;

  assign busy = 1'b0;

  // first free pipe, lowest index wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int p = 0; p < NUM_PIPES; p++) begin
      if (!free_found && st_r[p].mode == MODE_FREE) begin
        free_found = 1'b1;
        free_idx   = PIPE_IDX_W'(p);
      end
    end
  end

  always_comb begin
    idx_ok      = 32'(idx_r) < NUM_PIPES;
    idx_sel     = PIPE_IDX_W'(idx_r);
    is_lease    = in_vld_r && op_r == OP_LEASE;
    is_status   = in_vld_r && op_r == OP_STATUS && idx_ok;
    status_used = idx_ok && st_r[idx_sel].mode == MODE_USED;
    grant       = is_lease && free_found;
  end

  always_comb begin
    for (int p = 0; p < NUM_PIPES; p++) begin
      ctrl[p].step       = in_vld_r;
      ctrl[p].lease_hit  = grant && free_idx == PIPE_IDX_W'(p);
      ctrl[p].status_hit = is_status && status_used && idx_sel == PIPE_IDX_W'(p);
      ctrl[p].err_hit    = is_status && !status_used && idx_sel == PIPE_IDX_W'(p);
    end
  end

  for (genvar g = 0; g < NUM_PIPES; g++) begin : g_pipe
    rplm_pipe_update u_pipe (
      .ctrl       (ctrl[g]),
      .cur        (st_r[g]),
      .now_ms     (now_r),
      .timeout_ms (timeout_r),
      .nxt        (st_nxt[g])
    );
  end

  always_comb begin
    ack_nxt   = '0;
    modes_nxt = '0;
    for (int p = 0; p < OUT_PIPES; p++) begin
      ack_nxt[p]           = st_nxt[p].ack;
      modes_nxt[2*p +: 2]  = st_nxt[p].mode;
    end
    if (grant) begin
      addr_nxt = req_r;
    end else if (is_status) begin
      addr_nxt = reply_addr_r[idx_sel];
    end else begin
      addr_nxt = '0;
    end
    lease_pipe_nxt = grant ? 3'(free_idx) : 3'd0;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
      for (int p = 0; p < NUM_PIPES; p++) begin
        st_r[p].mode       <= MODE_FREE;
        st_r[p].last_heard <= '0;
        st_r[p].ack        <= 1'b1;
      end
    end else begin
      in_vld_r    <= start && !busy;
      out_valid_r <= in_vld_r;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      for (int p = 0; p < NUM_PIPES; p++) begin
        st_r[p] <= st_nxt[p];
      end
    end
  end

  // payload: input transfer register, reply addresses and result register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r  <= in_opcode;
      now_r <= in_now_ms;
      idx_r <= in_pipe_index;
      req_r <= in_requester_addr;
    end
    if (grant) begin
      reply_addr_r[free_idx] <= req_r;
    end
    if (in_vld_r) begin
      ack_r        <= ack_nxt;
      modes_r      <= modes_nxt;
      addr_r       <= addr_nxt;
      granted_r    <= grant;
      full_r       <= is_lease && !free_found;
      lease_pipe_r <= lease_pipe_nxt;
      accepted_r   <= is_status && status_used;
      rejected_r   <= is_status && !status_used;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_ack_mask           = ack_r;
  assign out_lease_granted      = granted_r;
  assign out_lease_full         = full_r;
  assign out_lease_pipe         = lease_pipe_r;
  assign out_status_accepted    = accepted_r;
  assign out_status_rejected    = rejected_r;
  assign out_state_bits         = modes_r;
  assign out_granted_reply_addr = addr_r;

endmodule : radio_pipe_lease_manager_core
`default_nettype wire

/* dv/tb_radio_pipe_lease_manager_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radio_pipe_lease_manager_core
// Self-checking bench for the pipe lease table. Directed rows cover reset
// state, leasing up to full, timeout boundaries and timestamp wrap. Random
// rows follow under several silence timeouts. Results are checked field by
// field against a local copy of the table, or against a pinned row's values.
// ----------------------------------------------------------------------------
module tb_radio_pipe_lease_manager_core
  import rplm_pkg::*;
();

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned DIR_ROWS = 19;

  typedef struct packed {
    logic [5:0]  ack_mask;
    logic        granted;
    logic        full;
    logic [2:0]  pipe;
    logic        accepted;
    logic        rejected;
    logic [11:0] state_bits;
    logic [39:0] reply_addr;
  } lease_result_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [31:0]   now;
    logic [2:0]    idx;
    logic [39:0]   addr;
    logic          pinned;
    lease_result_t want;
  } lease_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = OP_SWEEP;
  logic [31:0] in_now_ms = '0;
  logic [2:0]  in_pipe_index = '0;
  logic [39:0] in_requester_addr = '0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        out_valid;
  logic [5:0]  out_ack_mask;
  logic        out_lease_granted;
  logic        out_lease_full;
  logic [2:0]  out_lease_pipe;
  logic        out_status_accepted;
  logic        out_status_rejected;
  logic [11:0] out_state_bits;
  logic [39:0] out_granted_reply_addr;

  // local copy of the lease table
  mode_t       pipe_mode_m [NUM_PIPES];
  logic [31:0] heard_m [NUM_PIPES];
  logic        ack_m [NUM_PIPES];
  logic [39:0] addr_m [NUM_PIPES];
  bit          leased_once [NUM_PIPES];
  logic [15:0] timeout_m = TIMEOUT_RESET;

  lease_result_t pending_q [$];
  int unsigned   fail_count = 0;
  logic          pin_en = 1'b0;
  lease_result_t pin_res = '0;
  int unsigned   idle_pct = 30;
  logic [31:0]   clock_ms = 32'h0000_0400;
  lease_row_t    dir_tab [DIR_ROWS];

  radio_pipe_lease_manager_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_opcode              (in_opcode),
    .in_now_ms              (in_now_ms),
    .in_pipe_index          (in_pipe_index),
    .in_requester_addr      (in_requester_addr),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .out_valid              (out_valid),
    .out_ack_mask           (out_ack_mask),
    .out_lease_granted      (out_lease_granted),
    .out_lease_full         (out_lease_full),
    .out_lease_pipe         (out_lease_pipe),
    .out_status_accepted    (out_status_accepted),
    .out_status_rejected    (out_status_rejected),
    .out_state_bits         (out_state_bits),
    .out_granted_reply_addr (out_granted_reply_addr)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic lease_result_t pack_result(input logic [5:0] ack, input logic g,
                                                input logic f, input logic [2:0] p,
                                                input logic a, input logic r,
                                                input logic [11:0] st,
                                                input logic [39:0] addr);
    return {ack, g, f, p, a, r, st, addr};
  endfunction

  function automatic logic silent_for(input logic [31:0] now, input int p);
    logic [31:0] gap;
    gap = now - heard_m[p];
    return gap > {16'd0, timeout_m};
  endfunction

  // lease or status first, then the silence sweep in pipe order
  function automatic lease_result_t apply_pipe_event(input logic [1:0] op,
                                                     input logic [31:0] now,
                                                     input logic [2:0] idx,
                                                     input logic [39:0] addr);
    lease_result_t res;
    int err_pipe;
    int slot;
    res = '0;
    err_pipe = -1;
    slot = -1;
    if (op == OP_LEASE) begin
      for (int p = NUM_PIPES - 1; p >= 0; p--)
        if (pipe_mode_m[p] == MODE_FREE) slot = p;
      if (slot >= 0) begin
        pipe_mode_m[slot] = MODE_USED;
        heard_m[slot] = now;
        addr_m[slot] = addr;
        leased_once[slot] = 1'b1;
        res.granted = 1'b1;
        res.pipe = slot[2:0];
        res.reply_addr = addr;
      end else begin
        res.full = 1'b1;
      end
    end else if (op == OP_STATUS && idx < NUM_PIPES) begin
      res.reply_addr = addr_m[idx];
      if (pipe_mode_m[idx] == MODE_USED) begin
        heard_m[idx] = now;
        res.accepted = 1'b1;
      end else begin
        err_pipe = int'(idx);
        res.rejected = 1'b1;
      end
    end
    for (int p = 0; p < NUM_PIPES; p++) begin
      if (pipe_mode_m[p] == MODE_RESET && silent_for(now, p)) begin
        pipe_mode_m[p] = MODE_FREE;
        ack_m[p] = 1'b1;
      end
      // a resetting error pipe can be freed and put back to resetting here
      if (p == err_pipe || (pipe_mode_m[p] == MODE_USED && silent_for(now, p))) begin
        pipe_mode_m[p] = MODE_RESET;
        ack_m[p] = 1'b0;
      end
    end
    for (int p = 0; p < NUM_PIPES && p < 6; p++) begin
      res.ack_mask[p] = ack_m[p];
      res.state_bits[2*p +: 2] = pipe_mode_m[p];
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [39:0] want,
                             input logic [39:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    lease_result_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_q.size() == 0) begin
          $error("result transfer with no expectation waiting");
          fail_count++;
        end else begin
          want = pending_q.pop_front();
          check_field("ack_mask", 40'(want.ack_mask), 40'(out_ack_mask));
          check_field("lease_granted", 40'(want.granted), 40'(out_lease_granted));
          check_field("lease_full", 40'(want.full), 40'(out_lease_full));
          check_field("lease_pipe", 40'(want.pipe), 40'(out_lease_pipe));
          check_field("status_accepted", 40'(want.accepted), 40'(out_status_accepted));
          check_field("status_rejected", 40'(want.rejected), 40'(out_status_rejected));
          check_field("state_bits", 40'(want.state_bits), 40'(out_state_bits));
          check_field("granted_reply_addr", want.reply_addr, out_granted_reply_addr);
        end
      end
      if (cfg_wr_en) timeout_m = cfg_wr_data;
      if (start && !busy) begin
        want = apply_pipe_event(in_opcode, in_now_ms, in_pipe_index, in_requester_addr);
        if (pin_en) want = pin_res;
        pending_q.push_back(want);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [31:0] now,
                           input logic [2:0] idx, input logic [39:0] addr,
                           input logic pinned, input lease_result_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_opcode <= op;
    in_now_ms <= now;
    in_pipe_index <= idx;
    in_requester_addr <= addr;
    pin_en <= pinned;
    pin_res <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random_item();
    logic [1:0]  op;
    logic [2:0]  idx;
    logic [31:0] step_ms;
    logic [39:0] addr;
    int          roll;
    int          q;
    bit          found;
    roll = $urandom_range(0, 99);
    op = (roll < 30) ? OP_LEASE : (roll < 75) ? OP_STATUS : (roll < 95) ? OP_SWEEP : OP_UNUSED;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      clock_ms = $urandom;
    end else begin
      if (roll < 10) step_ms = $urandom;
      else if (roll < 35) step_ms = {16'd0, timeout_m} + $urandom_range(0, 2) - 1;
      else step_ms = $urandom_range(0, timeout_m / 3 + 1);
      clock_ms = clock_ms + step_ms;
    end
    idx = 3'($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0) begin
      idx = 3'($urandom_range(6, 7));
    end else if (!leased_once[idx] ||
                 (pipe_mode_m[idx] != MODE_USED && $urandom_range(0, 1) == 1)) begin
      // steer status frames to a live pipe if any, never to one that was never leased
      found = 1'b0;
      for (int k = 0; k < NUM_PIPES; k++) begin
        q = (int'(idx) + k) % NUM_PIPES;
        if (pipe_mode_m[q] == MODE_USED) begin
          idx = q[2:0];
          found = 1'b1;
          break;
        end
      end
      if (!found && !leased_once[idx]) begin
        for (int k = 0; k < NUM_PIPES; k++) begin
          q = (int'(idx) + k) % NUM_PIPES;
          if (leased_once[q]) begin
            idx = q[2:0];
            found = 1'b1;
            break;
          end
        end
        if (!found) idx = 3'd6 + 3'($urandom_range(0, 1));
      end
    end
    addr = 40'({$urandom, $urandom});
    send_item(op, clock_ms, idx, addr, 1'b0, '0);
  endtask

  initial begin : stimulus
    logic [15:0] phase_timeout [NUM_PHASES];
    for (int p = 0; p < NUM_PIPES; p++) begin
      pipe_mode_m[p] = MODE_FREE;
      heard_m[p] = '0;
      ack_m[p] = 1'b1;
      addr_m[p] = '0;
      leased_once[p] = 1'b0;
    end
    phase_timeout = '{16'd0, 16'hFFFF, 16'd1, 16'd300, 16'd0, 16'd1000};
    phase_timeout[4] = 16'($urandom_range(2, 65534));

    dir_tab = '{
      '{OP_SWEEP, 32'd0, 3'd0, 40'd0, 1'b1,
        pack_result(6'h3F, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 12'h000, 40'd0)},
      '{OP_UNUSED, 32'hFFFF_FFFF, 3'd0, 40'd0, 1'b1,
        pack_result(6'h3F, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 12'h000, 40'd0)},
      '{OP_STATUS, 32'd0, 3'd7, 40'd0, 1'b1,
        pack_result(6'h3F, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 12'h000, 40'd0)},
      '{OP_STATUS, 32'd0, 3'd6, 40'd0, 1'b1,
        pack_result(6'h3F, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 12'h000, 40'd0)},
      '{OP_LEASE, 32'd0, 3'd0, 40'hFF_FFFF_FFFF, 1'b1,
        pack_result(6'h3F, 1'b1, 1'b0, 3'd0, 1'b0, 1'b0, 12'h001, 40'hFF_FFFF_FFFF)},
      '{OP_LEASE, 32'd0, 3'd0, 40'd0, 1'b1,
        pack_result(6'h3F, 1'b1, 1'b0, 3'd1, 1'b0, 1'b0, 12'h005, 40'd0)},
      '{OP_LEASE, 32'd0, 3'd0, 40'hAA_AAAA_AAAA, 1'b1,
        pack_result(6'h3F, 1'b1, 1'b0, 3'd2, 1'b0, 1'b0, 12'h015, 40'hAA_AAAA_AAAA)},
      '{OP_LEASE, 32'd0, 3'd0, 40'h55_5555_5555, 1'b1,
        pack_result(6'h3F, 1'b1, 1'b0, 3'd3, 1'b0, 1'b0, 12'h055, 40'h55_5555_5555)},
      '{OP_LEASE, 32'd0, 3'd0, 40'h12_3456_789A, 1'b1,
        pack_result(6'h3F, 1'b1, 1'b0, 3'd4, 1'b0, 1'b0, 12'h155, 40'h12_3456_789A)},
      '{OP_LEASE, 32'd0, 3'd0, 40'h80_0000_0001, 1'b1,
        pack_result(6'h3F, 1'b1, 1'b0, 3'd5, 1'b0, 1'b0, 12'h555, 40'h80_0000_0001)},
      // table full
      '{OP_LEASE, 32'd0, 3'd0, 40'h00_FFFF_0000, 1'b1,
        pack_result(6'h3F, 1'b0, 1'b1, 3'd0, 1'b0, 1'b0, 12'h555, 40'd0)},
      '{OP_STATUS, 32'd500, 3'd0, 40'd0, 1'b1,
        pack_result(6'h3F, 1'b0, 1'b0, 3'd0, 1'b1, 1'b0, 12'h555, 40'hFF_FFFF_FFFF)},
      // silence exactly at the timeout keeps pipes alive
      '{OP_STATUS, 32'd1000, 3'd5, 40'd0, 1'b1,
        pack_result(6'h3F, 1'b0, 1'b0, 3'd0, 1'b1, 1'b0, 12'h555, 40'h80_0000_0001)},
      '{OP_SWEEP, 32'd1001, 3'd0, 40'd0, 1'b1,
        pack_result(6'h21, 1'b0, 1'b0, 3'd0, 1'b0, 1'b0, 12'h6A9, 40'd0)},
      // status on a resetting pipe that is also due to be freed
      '{OP_STATUS, 32'd2002, 3'd1, 40'd0, 1'b0, '0},
      '{OP_STATUS, 32'd2003, 3'd3, 40'd0, 1'b0, '0},
      '{OP_LEASE, 32'hFFFF_FFF0, 3'd0, 40'h3C_A5A5_5A5A, 1'b0, '0},
      // timestamp wrap
      '{OP_STATUS, 32'h0000_0010, 3'd2, 40'd0, 1'b0, '0},
      '{OP_SWEEP, 32'h0000_03F8, 3'd0, 40'd0, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_tab[i].op, dir_tab[i].now, dir_tab[i].idx, dir_tab[i].addr,
                dir_tab[i].pinned, dir_tab[i].want);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_timeout(phase_timeout[ph]);
      // one phase runs back to back with no sender gaps
      idle_pct = (ph == 2) ? 0 : 30;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random_item();
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("tb_radio_pipe_lease_manager_core passed");
    else $display("tb_radio_pipe_lease_manager_core failed");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_radio_pipe_lease_manager_core failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/rplm_pkg.sv
hdl/rplm_pipe_update.sv
hdl/radio_pipe_lease_manager_core.sv
dv/tb_radio_pipe_lease_manager_core.sv
